>>> src/edgp_pkg.sv
// ============================================================================
// edgp_pkg
// Shared constants and types for the emitter distance gain and pan block.
// ============================================================================
`default_nettype none

package edgp_pkg;

    // Field widths
    localparam int POS_WIDTH_DEF = 24;
    localparam int RAD_W         = 23;
    localparam int GAIN_W        = 16;
    localparam int GAIN_FRAC     = 15;

    // Derived arithmetic widths
    localparam int D2_W   = 2 * RAD_W;                   // squared distance
    localparam int ATT_W  = GAIN_FRAC + 1;               // attenuation, up to unity
    localparam int MAG_W  = 15;                          // pan offset magnitude
    localparam int PNUM_W = RAD_W + MAG_W;               // pan dividend
    localparam int ANUM_W = RAD_W + GAIN_FRAC;           // attenuation dividend
    localparam int P1_W   = 2 * GAIN_W - GAIN_FRAC;      // gain chain, first product
    localparam int P2_W   = P1_W + GAIN_W - GAIN_FRAC;
    localparam int P3_W   = P2_W + GAIN_W - GAIN_FRAC;
    localparam int P4_W   = P3_W + ATT_W - GAIN_FRAC;

    // Constants
    localparam logic [GAIN_W-1:0] VOL_RESET  = 16'd32768;
    localparam logic [GAIN_W-1:0] UNITY      = 16'd32768;
    localparam logic [15:0]       PAN_CENTRE = 16'd32768;
    localparam logic [MAG_W-1:0]  PAN_SPAN   = 15'd22938;   // round(0.35 * 65536)

    // Per-request data carried down the pipeline
    typedef struct packed {
        logic              aud;
        logic              pan_on;
        logic              dx_pos;
        logic [RAD_W-1:0]  radius;
        logic [P3_W-1:0]   prod;
        logic [PNUM_W-1:0] pnum;
        logic [ATT_W-1:0]  att;
        logic [MAG_W-1:0]  mag;
    } t_side;

    // Result payload
    typedef struct packed {
        logic        audible;
        logic [15:0] gain;
        logic [15:0] pan;
    } t_res;

endpackage

`default_nettype wire

>>> src/edgp_if.sv
// ============================================================================
// edgp_if
// Valid/ready channel interfaces: emitter request, result and volume write.
// ============================================================================
`default_nettype none

interface edgp_in_if #(
    parameter int POS_WIDTH = edgp_pkg::POS_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [POS_WIDTH-1:0]         emitter_x;
    logic signed [POS_WIDTH-1:0]         emitter_y;
    logic signed [POS_WIDTH-1:0]         listener_x;
    logic signed [POS_WIDTH-1:0]         listener_y;
    logic [edgp_pkg::RAD_W-1:0]          radius;
    logic [edgp_pkg::GAIN_W-1:0]         asset_gain;
    logic [edgp_pkg::GAIN_W-1:0]         emitter_gain;
    logic [edgp_pkg::GAIN_W-1:0]         authored_gain;
    logic                                pan_enable;

    modport source (output valid, emitter_x, emitter_y, listener_x, listener_y, radius,
                    asset_gain, emitter_gain, authored_gain, pan_enable, input ready);
    modport sink   (input valid, emitter_x, emitter_y, listener_x, listener_y, radius,
                    asset_gain, emitter_gain, authored_gain, pan_enable, output ready);
endinterface

interface edgp_out_if;
    logic        valid;
    logic        ready;
    logic        audible;
    logic [15:0] gain;
    logic [15:0] pan;

    modport source (output valid, audible, gain, pan, input ready);
    modport sink   (input valid, audible, gain, pan, output ready);
endinterface

interface edgp_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [edgp_pkg::GAIN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/edgp_front.sv
// ============================================================================
// edgp_front
// Four-stage front end: offsets, range test, squares and the gain products.
// ============================================================================
`default_nettype none

module edgp_front #(
    parameter int POS_WIDTH = edgp_pkg::POS_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_adv,
    input  wire logic                              i_v,
    input  wire logic signed [POS_WIDTH-1:0]       i_ex,
    input  wire logic signed [POS_WIDTH-1:0]       i_ey,
    input  wire logic signed [POS_WIDTH-1:0]       i_lx,
    input  wire logic signed [POS_WIDTH-1:0]       i_ly,
    input  wire logic [edgp_pkg::RAD_W-1:0]        i_radius,
    input  wire logic [edgp_pkg::GAIN_W-1:0]       i_asset,
    input  wire logic [edgp_pkg::GAIN_W-1:0]       i_emit,
    input  wire logic [edgp_pkg::GAIN_W-1:0]       i_auth,
    input  wire logic                              i_pan_en,
    input  wire logic [edgp_pkg::GAIN_W-1:0]       i_vol,
    output logic                                   o_v,
    output logic [edgp_pkg::D2_W-1:0]              o_d2,
    output edgp_pkg::t_side                        o_side
);

    localparam int DW = POS_WIDTH + 1;
    localparam int CW = (DW > edgp_pkg::RAD_W) ? DW : edgp_pkg::RAD_W;
    localparam int GF = edgp_pkg::GAIN_FRAC;

    // ---- Stage A: capture request ----
    logic                               r_a_v;
    logic signed [POS_WIDTH-1:0]        r_a_ex, r_a_ey, r_a_lx, r_a_ly;
    logic [edgp_pkg::RAD_W-1:0]         r_a_r;
    logic [edgp_pkg::GAIN_W-1:0]        r_a_asset, r_a_emit, r_a_auth;
    logic                               r_a_pan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_ex    <= i_ex;
            r_a_ey    <= i_ey;
            r_a_lx    <= i_lx;
            r_a_ly    <= i_ly;
            r_a_r     <= i_radius;
            r_a_asset <= i_asset;
            r_a_emit  <= i_emit;
            r_a_auth  <= i_auth;
            r_a_pan   <= i_pan_en;
        end
    end

    // ---- Stage B: offsets, magnitudes, range test, first gain product ----
    logic signed [DW-1:0]               dx, dy;
    logic [DW-1:0]                      adx, ady;
    logic                               near;
    logic [2*edgp_pkg::GAIN_W-1:0]      prod1;

    assign dx    = DW'(r_a_ex) - DW'(r_a_lx);
    assign dy    = DW'(r_a_ey) - DW'(r_a_ly);
    assign adx   = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign near  = (r_a_r != '0) && (CW'(adx) < CW'(r_a_r)) && (CW'(ady) < CW'(r_a_r));
    assign prod1 = r_a_asset * i_vol;

    logic                               r_b_v;
    logic [edgp_pkg::RAD_W-1:0]         r_b_adx, r_b_ady, r_b_r;
    logic                               r_b_near, r_b_pan, r_b_dxpos;
    logic [edgp_pkg::P1_W-1:0]          r_b_p;
    logic [edgp_pkg::GAIN_W-1:0]        r_b_emit, r_b_auth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_adx   <= edgp_pkg::RAD_W'(adx);
            r_b_ady   <= edgp_pkg::RAD_W'(ady);
            r_b_r     <= r_a_r;
            r_b_near  <= near;
            r_b_pan   <= r_a_pan;
            r_b_dxpos <= !dx[DW-1] && (dx != '0);
            r_b_p     <= prod1[edgp_pkg::P1_W+GF-1:GF];
            r_b_emit  <= r_a_emit;
            r_b_auth  <= r_a_auth;
        end
    end

    // ---- Stage C: squares, radius square, pan dividend, second gain product ----
    logic [edgp_pkg::D2_W-1:0]                  sqx, sqy, rr;
    logic [edgp_pkg::PNUM_W-1:0]                pnum;
    logic [edgp_pkg::P1_W+edgp_pkg::GAIN_W-1:0] prod2;

    assign sqx   = r_b_adx * r_b_adx;
    assign sqy   = r_b_ady * r_b_ady;
    assign rr    = r_b_r * r_b_r;
    assign pnum  = r_b_adx * edgp_pkg::PAN_SPAN;
    assign prod2 = r_b_p * r_b_emit;

    logic                               r_c_v;
    logic [edgp_pkg::D2_W-1:0]          r_c_sqx, r_c_sqy, r_c_rr;
    logic [edgp_pkg::PNUM_W-1:0]        r_c_pnum;
    logic [edgp_pkg::RAD_W-1:0]         r_c_r;
    logic                               r_c_near, r_c_pan, r_c_dxpos;
    logic [edgp_pkg::P2_W-1:0]          r_c_p;
    logic [edgp_pkg::GAIN_W-1:0]        r_c_auth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_sqx   <= sqx;
            r_c_sqy   <= sqy;
            r_c_rr    <= rr;
            r_c_pnum  <= pnum;
            r_c_r     <= r_b_r;
            r_c_near  <= r_b_near;
            r_c_pan   <= r_b_pan;
            r_c_dxpos <= r_b_dxpos;
            r_c_p     <= prod2[edgp_pkg::P2_W+GF-1:GF];
            r_c_auth  <= r_b_auth;
        end
    end

    // ---- Stage D: squared distance, audibility, third gain product ----
    logic [edgp_pkg::D2_W:0]                    d2;
    logic [edgp_pkg::P2_W+edgp_pkg::GAIN_W-1:0] prod3;

    assign d2    = r_c_sqx + r_c_sqy;
    assign prod3 = r_c_p * r_c_auth;

    logic                               r_d_v;
    logic [edgp_pkg::D2_W-1:0]          r_d_d2;
    edgp_pkg::t_side                    r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_adv) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_d2          <= d2[edgp_pkg::D2_W-1:0];
            r_d_side.aud    <= r_c_near && (d2 < {1'b0, r_c_rr});
            r_d_side.pan_on <= r_c_pan;
            r_d_side.dx_pos <= r_c_dxpos;
            r_d_side.radius <= r_c_r;
            r_d_side.prod   <= prod3[edgp_pkg::P3_W+GF-1:GF];
            r_d_side.pnum   <= r_c_pnum;
            r_d_side.att    <= '0;
            r_d_side.mag    <= '0;
        end
    end

    assign o_v    = r_d_v;
    assign o_d2   = r_d_d2;
    assign o_side = r_d_side;

endmodule

`default_nettype wire

>>> src/edgp_isqrt.sv
// ============================================================================
// edgp_isqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ============================================================================
`default_nettype none

module edgp_isqrt #(
    parameter int X_W    = edgp_pkg::D2_W,
    parameter int SIDE_W = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_v,
    input  wire logic [X_W-1:0]      i_x,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_v,
    output logic [X_W/2-1:0]         o_root,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int R_W = X_W / 2;

    logic              c_v    [R_W];
    logic [X_W-1:0]    c_rem  [R_W];
    logic [R_W-1:0]    c_q    [R_W];
    logic [SIDE_W-1:0] c_side [R_W];

    logic              r_v    [R_W];
    logic [X_W-1:0]    r_rem  [R_W];
    logic [R_W-1:0]    r_q    [R_W];
    logic [SIDE_W-1:0] r_side [R_W];

    for (genvar s = 0; s < R_W; s++) begin : g_st
        localparam int B = R_W - 1 - s;
        logic [X_W:0] step;
        logic         take;

        // Stage input: module port or previous stage
        if (s == 0) begin : g_first
            assign c_v[s]    = i_v;
            assign c_rem[s]  = i_x;
            assign c_q[s]    = '0;
            assign c_side[s] = i_side;
        end else begin : g_next
            assign c_v[s]    = r_v[s-1];
            assign c_rem[s]  = r_rem[s-1];
            assign c_q[s]    = r_q[s-1];
            assign c_side[s] = r_side[s-1];
        end

        // Try setting root bit B: (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        assign step = ((X_W+1)'(c_q[s]) << (B + 1)) + ((X_W+1)'(1) << (2 * B));
        assign take = ({1'b0, c_rem[s]} >= step);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_adv) begin
                r_v[s] <= c_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s]  <= take ? (c_rem[s] - step[X_W-1:0]) : c_rem[s];
                r_q[s]    <= take ? (c_q[s] | (R_W'(1) << B)) : c_q[s];
                r_side[s] <= c_side[s];
            end
        end
    end

    assign o_v    = r_v[R_W-1];
    assign o_root = r_q[R_W-1];
    assign o_side = r_side[R_W-1];

endmodule

`default_nettype wire

>>> src/edgp_div.sv
// ============================================================================
// edgp_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ============================================================================
`default_nettype none

module edgp_div #(
    parameter int NUM_W  = 38,
    parameter int DEN_W  = 23,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic                i_v,
    input  wire logic [NUM_W-1:0]    i_num,
    input  wire logic [DEN_W-1:0]    i_den,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_v,
    output logic [Q_W-1:0]           o_q,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              c_v    [Q_W];
    logic [W-1:0]      c_rem  [Q_W];
    logic [DEN_W-1:0]  c_den  [Q_W];
    logic [Q_W-1:0]    c_q    [Q_W];
    logic [SIDE_W-1:0] c_side [Q_W];

    logic              r_v    [Q_W];
    logic [W-1:0]      r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_q    [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_st
        localparam int B = Q_W - 1 - s;
        logic [W-1:0] trial;
        logic         take;

        // Stage input: module port or previous stage
        if (s == 0) begin : g_first
            assign c_v[s]    = i_v;
            assign c_rem[s]  = W'(i_num);
            assign c_den[s]  = i_den;
            assign c_q[s]    = '0;
            assign c_side[s] = i_side;
        end else begin : g_next
            assign c_v[s]    = r_v[s-1];
            assign c_rem[s]  = r_rem[s-1];
            assign c_den[s]  = r_den[s-1];
            assign c_q[s]    = r_q[s-1];
            assign c_side[s] = r_side[s-1];
        end

        // Subtract the shifted divisor when it fits
        assign trial = W'(c_den[s]) << B;
        assign take  = (c_rem[s] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_adv) begin
                r_v[s] <= c_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s]  <= take ? (c_rem[s] - trial) : c_rem[s];
                r_den[s]  <= c_den[s];
                r_q[s]    <= take ? (c_q[s] | (Q_W'(1) << B)) : c_q[s];
                r_side[s] <= c_side[s];
            end
        end
    end

    assign o_v    = r_v[Q_W-1];
    assign o_q    = r_q[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

`default_nettype wire

>>> src/edgp_back.sv
// ============================================================================
// edgp_back
// Two-stage back end: squared attenuation, pan, final gain and saturation.
// ============================================================================
`default_nettype none

module edgp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_v,
    input  wire edgp_pkg::t_side   i_side,
    output logic                   o_v,
    output edgp_pkg::t_res         o_res
);

    localparam int GF = edgp_pkg::GAIN_FRAC;

    // ---- Stage 1: attenuation squared and pan ----
    logic [2*edgp_pkg::ATT_W-1:0] att_sq;
    logic [15:0]                  pan;

    assign att_sq = i_side.att * i_side.att;

    always_comb begin
        pan = edgp_pkg::PAN_CENTRE;
        if (i_side.pan_on) begin
            if (i_side.dx_pos) begin
                pan = edgp_pkg::PAN_CENTRE - 16'(i_side.mag);
            end else begin
                pan = edgp_pkg::PAN_CENTRE + 16'(i_side.mag);
            end
        end
    end

    logic                         r_s1_v;
    logic                         r_s1_aud;
    logic [edgp_pkg::ATT_W-1:0]   r_s1_att2;
    logic [edgp_pkg::P3_W-1:0]    r_s1_prod;
    logic [15:0]                  r_s1_pan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_aud  <= i_side.aud;
            r_s1_att2 <= att_sq[edgp_pkg::ATT_W+GF-1:GF];
            r_s1_prod <= i_side.prod;
            r_s1_pan  <= pan;
        end
    end

    // ---- Stage 2: last gain product, saturate, mask inaudible ----
    logic [edgp_pkg::P3_W+edgp_pkg::ATT_W-1:0] prod4;
    logic [edgp_pkg::P4_W-1:0]                 g4;
    logic [15:0]                               gain_sat;

    assign prod4    = r_s1_prod * r_s1_att2;
    assign g4       = prod4[edgp_pkg::P4_W+GF-1:GF];
    assign gain_sat = (g4 > edgp_pkg::P4_W'(edgp_pkg::UNITY)) ? edgp_pkg::UNITY : 16'(g4);

    logic            r_s2_v;
    edgp_pkg::t_res  r_s2_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_res.audible <= r_s1_aud;
            r_s2_res.gain    <= r_s1_aud ? gain_sat : 16'd0;
            r_s2_res.pan     <= r_s1_aud ? r_s1_pan : edgp_pkg::PAN_CENTRE;
        end
    end

    assign o_v   = r_s2_v;
    assign o_res = r_s2_res;

endmodule

`default_nettype wire

>>> src/emitter_distance_gain_and_pan_top.sv
// ============================================================================
// emitter_distance_gain_and_pan_top
// Distance attenuation and stereo pan for one emitter request per cycle unless stalled.
// ============================================================================
//  Channel  | Dir | Handshake     | Moves
//  i_req    | in  | valid / ready | emitter and listener position, radius, gains
//  o_res    | out | valid / ready | audible flag, gain Q1.15, pan Q0.16
//  i_cfg    | in  | valid / ready | sound volume write (always ready)
//
//  One request per cycle while the skid register is empty; 61 register stages
//  lie between an accepted request and its valid result.
//  Most of them are the 23-stage square root and the 16- and 15-stage dividers.
//  Reset clears all valid bits and loads sound volume with unity.
//  A full output skid register stalls the whole pipeline; nothing is lost.
// ============================================================================
`default_nettype none

module emitter_distance_gain_and_pan_top #(
    parameter int POS_WIDTH = edgp_pkg::POS_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    edgp_in_if.sink     i_req,
    edgp_out_if.source  o_res,
    edgp_cfg_if.sink    i_cfg
);

    localparam int SIDE_W = $bits(edgp_pkg::t_side);

    // ---- Sound volume register ----
    logic [edgp_pkg::GAIN_W-1:0] r_vol;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= edgp_pkg::VOL_RESET;
        end else if (i_cfg.valid) begin
            r_vol <= i_cfg.data;
        end
    end

    // ---- Pipeline advance: hold all stages before the output register while the skid register is full ----
    logic r_sv;
    logic w_adv;

    assign w_adv       = !r_sv;
    assign i_req.ready = w_adv;

    // ---- Front end ----
    logic                        f_v;
    logic [edgp_pkg::D2_W-1:0]   f_d2;
    edgp_pkg::t_side             f_side;

    edgp_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_v     (i_req.valid),
        .i_ex    (i_req.emitter_x),
        .i_ey    (i_req.emitter_y),
        .i_lx    (i_req.listener_x),
        .i_ly    (i_req.listener_y),
        .i_radius(i_req.radius),
        .i_asset (i_req.asset_gain),
        .i_emit  (i_req.emitter_gain),
        .i_auth  (i_req.authored_gain),
        .i_pan_en(i_req.pan_enable),
        .i_vol   (r_vol),
        .o_v     (f_v),
        .o_d2    (f_d2),
        .o_side  (f_side)
    );

    // ---- Distance ----
    logic                        s_v;
    logic [edgp_pkg::RAD_W-1:0]  s_dist;
    logic [SIDE_W-1:0]           s_side_raw;
    edgp_pkg::t_side             s_side;

    edgp_isqrt #(.X_W(edgp_pkg::D2_W), .SIDE_W(SIDE_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_v    (f_v),
        .i_x    (f_d2),
        .i_side (f_side),
        .o_v    (s_v),
        .o_root (s_dist),
        .o_side (s_side_raw)
    );

    assign s_side = edgp_pkg::t_side'(s_side_raw);

    // ---- Attenuation: (radius - dist) * 2^G / radius ----
    logic [edgp_pkg::ANUM_W-1:0] a_num;
    logic                        a_v;
    logic [edgp_pkg::ATT_W-1:0]  a_q;
    logic [SIDE_W-1:0]           a_side_raw;
    edgp_pkg::t_side             a_side;

    assign a_num = edgp_pkg::ANUM_W'(s_side.radius - s_dist) << edgp_pkg::GAIN_FRAC;

    edgp_div #(
        .NUM_W (edgp_pkg::ANUM_W),
        .DEN_W (edgp_pkg::RAD_W),
        .Q_W   (edgp_pkg::ATT_W),
        .SIDE_W(SIDE_W)
    ) u_div_att (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_v    (s_v),
        .i_num  (a_num),
        .i_den  (s_side.radius),
        .i_side (s_side_raw),
        .o_v    (a_v),
        .o_q    (a_q),
        .o_side (a_side_raw)
    );

    always_comb begin
        a_side     = edgp_pkg::t_side'(a_side_raw);
        a_side.att = a_q;
    end

    // ---- Pan magnitude: |dx| * span / radius ----
    logic                        m_v;
    logic [edgp_pkg::MAG_W-1:0]  m_q;
    logic [SIDE_W-1:0]           m_side_raw;
    edgp_pkg::t_side             m_side;

    edgp_div #(
        .NUM_W (edgp_pkg::PNUM_W),
        .DEN_W (edgp_pkg::RAD_W),
        .Q_W   (edgp_pkg::MAG_W),
        .SIDE_W(SIDE_W)
    ) u_div_pan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_v    (a_v),
        .i_num  (a_side.pnum),
        .i_den  (a_side.radius),
        .i_side (a_side),
        .o_v    (m_v),
        .o_q    (m_q),
        .o_side (m_side_raw)
    );

    always_comb begin
        m_side     = edgp_pkg::t_side'(m_side_raw);
        m_side.mag = m_q;
    end

    // ---- Back end ----
    logic            b_v;
    edgp_pkg::t_res  b_res;

    edgp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_v    (m_v),
        .i_side (m_side),
        .o_v    (b_v),
        .o_res  (b_res)
    );

    // ---- Output register with skid ----
    logic            r_ov;
    edgp_pkg::t_res  r_out, r_skid;
    logic            w_take;

    assign w_take = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_take) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= b_v;
            end
        end else if (b_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_sv ? r_skid : b_res;
        end else if (w_adv && b_v) begin
            r_skid <= b_res;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.audible = r_out.audible;
    assign o_res.gain    = r_out.gain;
    assign o_res.pan     = r_out.pan;

    // ---- Assertions ----
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a result while output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !o_res.ready) |=> (r_sv && $stable(r_skid)))
        else $error("skid result lost under stall");

    a_inaudible_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.audible) |-> (r_out.gain == 16'd0 &&
                                      r_out.pan == edgp_pkg::PAN_CENTRE))
        else $error("inaudible result carries gain or pan");

    a_gain_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.gain <= edgp_pkg::UNITY))
        else $error("gain above unity");

endmodule

`default_nettype wire
